>>> rtl/ffill_pkg.sv
// Shared types, codes and constants of the four-way flood fill block.
package ffill_pkg;

  // Default geometry and pixel size
  localparam int unsigned MAX_COLUMNS_DEF = 64;
  localparam int unsigned MAX_ROWS_DEF    = 64;
  localparam int unsigned PIXEL_BITS_DEF  = 32;

  // Fixed field widths of the channels and the configuration port
  localparam int unsigned ACTION_W   = 2;
  localparam int unsigned COORD_W    = 6;
  localparam int unsigned COLOR_W    = 32;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 7;

  // Register reset values
  localparam logic [6:0] FRAME_WIDTH_RST  = 7'd64;
  localparam logic [6:0] FRAME_HEIGHT_RST = 7'd64;
  localparam logic [6:0] CLIP_COLS_RST    = 7'd64;
  localparam logic [6:0] CLIP_ROWS_RST    = 7'd64;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 3'd0,
    CFG_FRAME_HEIGHT = 3'd1,
    CFG_CLIP_ENABLE  = 3'd2,
    CFG_CLIP_LEFT    = 3'd3,
    CFG_CLIP_TOP     = 3'd4,
    CFG_CLIP_COLUMNS = 3'd5,
    CFG_CLIP_ROWS    = 3'd6
  } cfg_idx_e;

  // Item actions
  typedef enum logic [ACTION_W-1:0] {
    ACT_WRITE = 2'd0,
    ACT_READ  = 2'd1,
    ACT_FILL  = 2'd2
  } action_e;

  // Neighbor visiting order
  typedef enum logic [1:0] {
    DIR_RIGHT = 2'd0,
    DIR_LEFT  = 2'd1,
    DIR_DOWN  = 2'd2,
    DIR_UP    = 2'd3
  } dir_e;

  // What the result register is loaded with
  typedef enum logic [1:0] {
    RES_ZERO    = 2'd0,
    RES_PIXEL   = 2'd1,
    RES_CHANGED = 2'd2
  } res_e;

  // Controller to datapath
  typedef struct packed {
    logic in_ready;
    logic acc_write;   // write pixel at the input coordinate
    logic acc_read;    // read pixel at the input coordinate
    logic acc_seed;    // read seed, latch seed and paint color
    logic ld_target;   // take the seed color as target
    logic seed_paint;  // paint and push the seed, stack restarts
    logic pop;         // pop one pixel from the stack
    logic load_cur;    // latch popped pixel, restart neighbor walk
    logic use_dir;     // probe the neighbor instead of the current pixel
    logic nb_read;     // read the neighbor pixel
    logic nb_paint;    // paint and push the neighbor
    logic dir_next;
    logic res_valid;
    res_e res_kind;
  } ffill_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic    in_valid;
    action_e in_action;
    logic    in_addr_ok;      // input coordinate inside the store
    logic    seed_in_frame;   // input coordinate inside the frame in use
    logic    target_is_paint;
    logic    probe_ok;        // probed pixel exists and lies in the fill area
    logic    pixel_match;     // neighbor holds the target color
    logic    stack_empty;
    logic    dir_last;
    logic    out_free;
  } ffill_status_t;

endpackage

>>> rtl/ffill_in_if.sv
// Input item channel: action, coordinate and color.
interface ffill_in_if import ffill_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [COORD_W-1:0]  column;
  logic [COORD_W-1:0]  row;
  logic [COLOR_W-1:0]  color;

  modport source (output valid, action, column, row, color, input ready);
  modport sink   (input valid, action, column, row, color, output ready);
endinterface

>>> rtl/ffill_out_if.sv
// Result item channel: pixel read back and fill flag.
interface ffill_out_if import ffill_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COLOR_W-1:0] pixel_value;
  logic               fill_changed;

  modport source (output valid, pixel_value, fill_changed, input ready);
  modport sink   (input valid, pixel_value, fill_changed, output ready);
endinterface

>>> rtl/four_way_flood_fill.sv
// Top level of the four-way flood fill block: frame store with pixel access and fill.
//
//   channel  dir  handshake     payload
//   in_i     in   valid/ready   action, column, row, color
//   out_o    out  valid/ready   pixel_value, fill_changed
//   cfg      in   cfg_we_i      cfg_index_i, cfg_data_i (7 bits)
//
// A pixel write ends in the idle state, a pixel read in the READ state (registered
// memory read). A fill with its seed outside the frame ends in the idle state like a
// write; otherwise the SEED state rejects or starts it, then each repainted pixel
// passes POP and LOAD (stack pop), NREAD alone per neighbor outside the fill area and
// NREAD then NCHK per neighbor inside (registered frame read, then compare and paint),
// and a last POP on the empty stack; input is held off until the fill is done.
// Reset clears control state; the frame and stack memories start undefined.
// A held result stalls only the next item; one result waits in the output register.
module four_way_flood_fill import ffill_pkg::*; #(
  parameter int unsigned MAX_COLUMNS = MAX_COLUMNS_DEF,
  parameter int unsigned MAX_ROWS    = MAX_ROWS_DEF,
  parameter int unsigned PIXEL_BITS  = PIXEL_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  ffill_in_if.sink              in_i,
  ffill_out_if.source           out_o
);

  ffill_cmd_t    cmd;
  ffill_status_t status;

  ffill_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .cmd_o    (cmd)
  );

  ffill_dp #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS),
    .PIXEL_BITS  (PIXEL_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_i        (in_i),
    .out_o       (out_o),
    .cmd_i       (cmd),
    .status_o    (status)
  );

endmodule

>>> rtl/ffill_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ffill_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 4096,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/ffill_dp.sv
// Datapath: config registers, frame and stack memories, coordinates, result register.
module ffill_dp import ffill_pkg::*; #(
  parameter int unsigned MAX_COLUMNS = MAX_COLUMNS_DEF,
  parameter int unsigned MAX_ROWS    = MAX_ROWS_DEF,
  parameter int unsigned PIXEL_BITS  = PIXEL_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  ffill_in_if.sink              in_i,
  ffill_out_if.source           out_o,
  input  ffill_cmd_t            cmd_i,
  output ffill_status_t         status_o
);

  localparam int unsigned XW    = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int unsigned YW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned DEPTH = MAX_COLUMNS * MAX_ROWS;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned SPW   = $clog2(DEPTH + 1);
  localparam int unsigned KWX   = $clog2(MAX_COLUMNS + 1);
  localparam int unsigned KWY   = $clog2(MAX_ROWS + 1);
  localparam int unsigned KW0   = (KWX > KWY) ? KWX : KWY;
  // compare width: holds a neighbor one past the edge and clip sums
  localparam int unsigned KW    = (KW0 > 8) ? KW0 : 8;

  // Configuration registers
  logic [6:0] frame_width_q, frame_height_q, clip_cols_q, clip_rows_q;
  logic [5:0] clip_left_q, clip_top_q;
  logic       clip_en_q;

  // Walk state
  logic [XW-1:0]         cur_x_q;
  logic [YW-1:0]         cur_y_q;
  logic [PIXEL_BITS-1:0] target_q, paint_q;
  logic [SPW-1:0]        sp_q, sp_d;
  dir_e                  dir_q, dir_d;

  // Result register
  logic               out_valid_q, out_valid_d;
  logic [COLOR_W-1:0] pixel_q;
  logic               changed_q;

  // Memory ports
  logic                  frame_we, frame_re;
  logic [AW-1:0]         frame_waddr, frame_raddr;
  logic [PIXEL_BITS-1:0] frame_wdata, frame_rdata;
  logic                  stack_we;
  logic [AW-1:0]         stack_raddr;
  logic [XW+YW-1:0]      stack_wdata, stack_rdata;

  // Coordinates
  logic [KW-1:0] in_x, in_y, eff_w, eff_h;
  logic [KW-1:0] px, py, clip_right, clip_bottom;
  logic [AW-1:0] in_addr, probe_addr;
  logic          probe_exists, probe_inside;

  // Config writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= FRAME_WIDTH_RST;
      frame_height_q <= FRAME_HEIGHT_RST;
      clip_en_q      <= 1'b0;
      clip_left_q    <= '0;
      clip_top_q     <= '0;
      clip_cols_q    <= CLIP_COLS_RST;
      clip_rows_q    <= CLIP_ROWS_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_FRAME_WIDTH:  frame_width_q  <= cfg_data_i;
        CFG_FRAME_HEIGHT: frame_height_q <= cfg_data_i;
        CFG_CLIP_ENABLE:  clip_en_q      <= cfg_data_i[0];
        CFG_CLIP_LEFT:    clip_left_q    <= cfg_data_i[5:0];
        CFG_CLIP_TOP:     clip_top_q     <= cfg_data_i[5:0];
        CFG_CLIP_COLUMNS: clip_cols_q    <= cfg_data_i;
        CFG_CLIP_ROWS:    clip_rows_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Frame size in use, saturated to the store
  assign eff_w = (KW'(frame_width_q) > KW'(MAX_COLUMNS)) ? KW'(MAX_COLUMNS)
                                                         : KW'(frame_width_q);
  assign eff_h = (KW'(frame_height_q) > KW'(MAX_ROWS)) ? KW'(MAX_ROWS)
                                                       : KW'(frame_height_q);
  assign clip_right  = KW'(clip_left_q) + KW'(clip_cols_q);
  assign clip_bottom = KW'(clip_top_q) + KW'(clip_rows_q);

  // Input coordinate checks
  assign in_x    = KW'(in_i.column);
  assign in_y    = KW'(in_i.row);
  assign in_addr = AW'(AW'(in_i.row) * AW'(MAX_COLUMNS) + AW'(in_i.column));

  // Probe: current pixel or its neighbor in the walk direction
  always_comb begin
    px           = KW'(cur_x_q);
    py           = KW'(cur_y_q);
    probe_exists = 1'b1;
    if (cmd_i.use_dir) begin
      case (dir_q)
        DIR_RIGHT: px = KW'(cur_x_q) + KW'(1);
        DIR_LEFT: begin
          px           = KW'(cur_x_q) - KW'(1);
          probe_exists = (cur_x_q != '0);
        end
        DIR_DOWN:  py = KW'(cur_y_q) + KW'(1);
        DIR_UP: begin
          py           = KW'(cur_y_q) - KW'(1);
          probe_exists = (cur_y_q != '0);
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    probe_inside = (px < eff_w) && (py < eff_h);
    if (clip_en_q) begin
      probe_inside = probe_inside &&
                     (px >= KW'(clip_left_q)) && (px < clip_right) &&
                     (py >= KW'(clip_top_q)) && (py < clip_bottom);
    end
  end

  assign probe_addr = AW'(AW'(py) * AW'(MAX_COLUMNS) + AW'(px));

  // Frame store
  assign frame_we    = (cmd_i.acc_write && status_o.in_addr_ok) ||
                       cmd_i.seed_paint || cmd_i.nb_paint;
  assign frame_waddr = cmd_i.acc_write ? in_addr : probe_addr;
  assign frame_wdata = cmd_i.acc_write ? in_i.color[PIXEL_BITS-1:0] : paint_q;
  assign frame_re    = cmd_i.acc_read || cmd_i.acc_seed || cmd_i.nb_read;
  assign frame_raddr = (cmd_i.acc_read || cmd_i.acc_seed) ? in_addr : probe_addr;

  ffill_ram #(
    .WIDTH (PIXEL_BITS),
    .DEPTH (DEPTH)
  ) u_frame_ram (
    .clk_i   (clk_i),
    .we_i    (frame_we),
    .waddr_i (frame_waddr),
    .wdata_i (frame_wdata),
    .re_i    (frame_re),
    .raddr_i (frame_raddr),
    .rdata_o (frame_rdata)
  );

  // Pending stack, holds {row, column}
  assign stack_we    = cmd_i.seed_paint || cmd_i.nb_paint;
  assign stack_wdata = {YW'(py), XW'(px)};
  assign stack_raddr = AW'(sp_q - SPW'(1));

  ffill_ram #(
    .WIDTH (XW + YW),
    .DEPTH (DEPTH)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (stack_we),
    .waddr_i (AW'(sp_q)),
    .wdata_i (stack_wdata),
    .re_i    (cmd_i.pop),
    .raddr_i (stack_raddr),
    .rdata_o (stack_rdata)
  );

  // Stack pointer and walk direction
  always_comb begin
    sp_d = sp_q;
    if (cmd_i.seed_paint) begin
      sp_d = SPW'(1);
    end else if (cmd_i.nb_paint) begin
      sp_d = sp_q + SPW'(1);
    end else if (cmd_i.pop) begin
      sp_d = sp_q - SPW'(1);
    end
  end

  always_comb begin
    dir_d = dir_q;
    if (cmd_i.load_cur) begin
      dir_d = DIR_RIGHT;
    end else if (cmd_i.dir_next) begin
      case (dir_q)
        DIR_RIGHT: dir_d = DIR_LEFT;
        DIR_LEFT:  dir_d = DIR_DOWN;
        DIR_DOWN:  dir_d = DIR_UP;
        default:   dir_d = DIR_RIGHT;
      endcase
    end
  end

  assign out_valid_d = cmd_i.res_valid ? 1'b1 : (out_valid_q && !out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sp_q        <= '0;
      dir_q       <= DIR_RIGHT;
      out_valid_q <= 1'b0;
    end else begin
      sp_q        <= sp_d;
      dir_q       <= dir_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.acc_seed) begin
      cur_x_q <= XW'(in_i.column);
      cur_y_q <= YW'(in_i.row);
      paint_q <= in_i.color[PIXEL_BITS-1:0];
    end else if (cmd_i.load_cur) begin
      cur_x_q <= stack_rdata[XW-1:0];
      cur_y_q <= stack_rdata[XW +: YW];
    end
    if (cmd_i.ld_target) begin
      target_q <= frame_rdata;
    end
    if (cmd_i.res_valid) begin
      case (cmd_i.res_kind)
        RES_PIXEL: begin
          pixel_q   <= COLOR_W'(frame_rdata);
          changed_q <= 1'b0;
        end
        RES_CHANGED: begin
          pixel_q   <= '0;
          changed_q <= 1'b1;
        end
        default: begin
          pixel_q   <= '0;
          changed_q <= 1'b0;
        end
      endcase
    end
  end

  // Channel outputs
  assign in_i.ready         = cmd_i.in_ready;
  assign out_o.valid        = out_valid_q;
  assign out_o.pixel_value  = pixel_q;
  assign out_o.fill_changed = changed_q;

  // Status to the controller
  assign status_o.in_valid        = in_i.valid;
  assign status_o.in_action       = action_e'(in_i.action);
  assign status_o.in_addr_ok      = (in_x < KW'(MAX_COLUMNS)) && (in_y < KW'(MAX_ROWS));
  assign status_o.seed_in_frame   = (in_x < eff_w) && (in_y < eff_h);
  assign status_o.target_is_paint = (frame_rdata == paint_q);
  assign status_o.probe_ok        = probe_exists && probe_inside;
  assign status_o.pixel_match     = (frame_rdata == target_q);
  assign status_o.stack_empty     = (sp_q == '0);
  assign status_o.dir_last        = (dir_q == DIR_UP);
  assign status_o.out_free        = !out_valid_q || out_o.ready;

endmodule

>>> rtl/ffill_ctrl.sv
// Controller: sequences pixel access and the stack walk of a fill.
module ffill_ctrl import ffill_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  ffill_status_t status_i,
  output ffill_cmd_t    cmd_o
);

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_READ  = 7'b0000010,
    ST_SEED  = 7'b0000100,
    ST_POP   = 7'b0001000,
    ST_LOAD  = 7'b0010000,
    ST_NREAD = 7'b0100000,
    ST_NCHK  = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  // Next state and commands
  always_comb begin
    cmd_o          = '0;
    cmd_o.res_kind = RES_ZERO;
    state_d        = state_q;
    case (state_q)
      ST_IDLE: begin
        cmd_o.in_ready = status_i.out_free;
        if (status_i.in_valid && status_i.out_free) begin
          case (status_i.in_action)
            ACT_WRITE: begin
              cmd_o.acc_write = 1'b1;
              cmd_o.res_valid = 1'b1;
            end
            ACT_READ: begin
              if (status_i.in_addr_ok) begin
                cmd_o.acc_read = 1'b1;
                state_d        = ST_READ;
              end else begin
                cmd_o.res_valid = 1'b1;
              end
            end
            ACT_FILL: begin
              if (status_i.seed_in_frame) begin
                cmd_o.acc_seed = 1'b1;
                state_d        = ST_SEED;
              end else begin
                cmd_o.res_valid = 1'b1;
              end
            end
            default: cmd_o.res_valid = 1'b1;
          endcase
        end
      end
      ST_READ: begin
        cmd_o.res_valid = 1'b1;
        cmd_o.res_kind  = RES_PIXEL;
        state_d         = ST_IDLE;
      end
      // seed color is in the read register
      ST_SEED: begin
        if (status_i.target_is_paint) begin
          cmd_o.res_valid = 1'b1;
          state_d         = ST_IDLE;
        end else begin
          cmd_o.ld_target = 1'b1;
          if (status_i.probe_ok) begin
            cmd_o.seed_paint = 1'b1;
            state_d          = ST_POP;
          end else begin
            cmd_o.res_valid = 1'b1;
            state_d         = ST_IDLE;
          end
        end
      end
      ST_POP: begin
        if (status_i.stack_empty) begin
          cmd_o.res_valid = 1'b1;
          cmd_o.res_kind  = RES_CHANGED;
          state_d         = ST_IDLE;
        end else begin
          cmd_o.pop = 1'b1;
          state_d   = ST_LOAD;
        end
      end
      ST_LOAD: begin
        cmd_o.load_cur = 1'b1;
        state_d        = ST_NREAD;
      end
      ST_NREAD: begin
        cmd_o.use_dir = 1'b1;
        if (status_i.probe_ok) begin
          cmd_o.nb_read = 1'b1;
          state_d       = ST_NCHK;
        end else if (status_i.dir_last) begin
          state_d = ST_POP;
        end else begin
          cmd_o.dir_next = 1'b1;
        end
      end
      ST_NCHK: begin
        cmd_o.use_dir  = 1'b1;
        cmd_o.nb_paint = status_i.pixel_match;
        if (status_i.dir_last) begin
          state_d = ST_POP;
        end else begin
          cmd_o.dir_next = 1'b1;
          state_d        = ST_NREAD;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
